[sv/rrl_pkg.sv]
// Package with widths, command and status codes and shared types of the ledger.
package rrl_pkg;
  localparam int MAX_CLASSES = 8;
  localparam int DEF_NUM_CLASSES = 8;
  localparam int DEF_SLOT_COUNT = 16;
  localparam int DEF_QTY_BITS = 48;
  localparam int FIELD_BITS = 48;
  localparam int CMD_BITS = 3;
  localparam int SLOT_BITS = 4;
  localparam int SEL_BITS = 3;
  localparam int STATUS_BITS = 3;

  localparam logic [CMD_BITS-1:0] CMD_RESERVE = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_COMMIT = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_ROLLBACK = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_SNAPSHOT = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NO_SLOT = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_STATE = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 3'd5;

  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic [SLOT_BITS-1:0] slot;
    logic [SEL_BITS-1:0] class_select;
    logic [MAX_CLASSES-1:0][FIELD_BITS-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0] granted_slot;
    logic [FIELD_BITS-1:0] reserved_level;
    logic [FIELD_BITS-1:0] used_level;
    logic [FIELD_BITS-1:0] peak_level;
  } rsp_t;

  // Per-lane findings handed to the merging stage.
  typedef struct packed {
    logic nonzero;
    logic fits;
    logic res_holds;
    logic used_holds;
  } lane_flags_t;
endpackage

[sv/rrl_if.sv]
// Valid/ready channel interfaces for requests, responses and configuration writes.
interface rrl_req_if;
  import rrl_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrl_rsp_if;
  import rrl_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrl_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [47:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[sv/resource_reservation_ledger_top.sv]
// Top level of the resource reservation ledger: lanes, slot table and merging stage.
// Each request first reads the slot amounts from memory into a register; then, in the
// execute state, the lanes' findings are merged and all totals update.
// A request is taken only in the idle state; execute holds while a response is still unread.
// The response sits in an output register; a new request is taken while it waits.
// Synchronous active-low reset clears capacities, totals and the valid and committed bits of all slots.
module resource_reservation_ledger_top #(
  parameter int NUM_CLASSES = rrl_pkg::DEF_NUM_CLASSES,
  parameter int SLOT_COUNT = rrl_pkg::DEF_SLOT_COUNT,
  parameter int QTY_BITS = rrl_pkg::DEF_QTY_BITS
) (
  input logic clk,
  input logic rst_n,
  rrl_req_if.sink in_req,
  rrl_rsp_if.source out_rsp,
  rrl_cfg_if.sink cfg_wr
);
  import rrl_pkg::*;
  localparam int FW = $clog2(SLOT_COUNT+1);

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_EXEC = 2'b10} state_t;
  state_t state_r, state_nxt;
  req_t req_r;
  rsp_t rsp_r, rsp_nxt;
  logic rsp_valid_r, rsp_valid_nxt;

  logic [NUM_CLASSES-1:0][QTY_BITS-1:0] req_amt, slot_amt;
  lane_flags_t [NUM_CLASSES-1:0] flags;
  logic [NUM_CLASSES-1:0][QTY_BITS-1:0] res_l, used_l, peak_l;
  logic do_reserve, do_sub_res, do_sub_used, do_add_used, alloc, commit, free;
  logic slot_ok, slot_comm, have_free;
  logic [FW-1:0] free_idx;
  logic any_nz, all_fit, res_ok, used_ok;
  logic accept;
  logic [SLOT_BITS-1:0] rd_slot;

  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign out_rsp.valid = rsp_valid_r;
  assign out_rsp.data = rsp_r;
  assign rd_slot = accept ? in_req.data.slot : req_r.slot;

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
    assign req_amt[c] = QTY_BITS'(req_r.amount[c]);
    rrl_lane #(.QTY_BITS(QTY_BITS)) u_lane (
      .clk(clk), .rst_n(rst_n),
      .cap_we(cfg_wr.valid && (32'(cfg_wr.index) == c)),
      .cap_wdata(cfg_wr.wdata),
      .req_amt(req_amt[c]), .slot_amt(slot_amt[c]),
      .do_reserve(do_reserve), .do_sub_res(do_sub_res),
      .do_sub_used(do_sub_used), .do_add_used(do_add_used),
      .flags(flags[c]), .res_o(res_l[c]), .used_o(used_l[c]), .peak_o(peak_l[c])
    );
  end

  rrl_slots #(.NUM_CLASSES(NUM_CLASSES), .SLOT_COUNT(SLOT_COUNT), .QTY_BITS(QTY_BITS))
  u_slots (
    .clk(clk), .rst_n(rst_n),
    .rd_slot(rd_slot), .rd_amt(slot_amt),
    .alloc(alloc), .alloc_amt(req_amt),
    .commit(commit), .free(free), .upd_slot(req_r.slot),
    .slot_ok(slot_ok), .slot_comm(slot_comm),
    .have_free(have_free), .free_idx(free_idx)
  );

  always_comb begin
    any_nz = 1'b0;
    all_fit = 1'b1;
    res_ok = 1'b1;
    used_ok = 1'b1;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      any_nz |= flags[c].nonzero;
      all_fit &= flags[c].fits;
      res_ok &= flags[c].res_holds;
      used_ok &= flags[c].used_holds;
    end
    do_reserve = 1'b0;
    do_sub_res = 1'b0;
    do_sub_used = 1'b0;
    do_add_used = 1'b0;
    alloc = 1'b0;
    commit = 1'b0;
    free = 1'b0;
    rsp_nxt = rsp_r;
    rsp_valid_nxt = rsp_valid_r && !out_rsp.ready;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!rsp_valid_r || out_rsp.ready) begin
          state_nxt = S_IDLE;
          rsp_valid_nxt = 1'b1;
          rsp_nxt = '0;
          rsp_nxt.status = ST_STATE;
          rsp_nxt.granted_slot = req_r.slot;
          case (req_r.command)
            CMD_RESERVE: begin
              if (!any_nz) rsp_nxt.status = ST_EMPTY;
              else if (!all_fit) rsp_nxt.status = ST_EXHAUSTED;
              else if (!have_free) rsp_nxt.status = ST_NO_SLOT;
              else begin
                do_reserve = 1'b1;
                alloc = 1'b1;
                rsp_nxt.status = ST_OK;
                rsp_nxt.granted_slot = SLOT_BITS'(free_idx);
              end
            end
            CMD_COMMIT, CMD_ROLLBACK: begin
              if (slot_ok && !slot_comm) begin
                if (!res_ok) rsp_nxt.status = ST_UNDERFLOW;
                else begin
                  rsp_nxt.status = ST_OK;
                  do_sub_res = 1'b1;
                  if (req_r.command == CMD_COMMIT) begin
                    do_add_used = 1'b1;
                    commit = 1'b1;
                  end else begin
                    free = 1'b1;
                  end
                end
              end
            end
            CMD_RELEASE: begin
              if (slot_ok) begin
                free = 1'b1;
                if (slot_comm ? used_ok : res_ok) begin
                  rsp_nxt.status = ST_OK;
                  do_sub_used = slot_comm;
                  do_sub_res = !slot_comm;
                end else begin
                  rsp_nxt.status = ST_UNDERFLOW;
                end
              end
            end
            CMD_SNAPSHOT: begin
              for (int c = 0; c < NUM_CLASSES; c++) begin
                if (32'(req_r.class_select) == c) begin
                  rsp_nxt.status = ST_OK;
                  rsp_nxt.reserved_level = FIELD_BITS'(res_l[c]);
                  rsp_nxt.used_level = FIELD_BITS'(used_l[c]);
                  rsp_nxt.peak_level = FIELD_BITS'(peak_l[c]);
                end
              end
            end
            default: rsp_nxt.status = ST_STATE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_req.data;
    rsp_r <= rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rsp_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rsp_valid_r <= rsp_valid_nxt;
    end
  end
endmodule

[sv/rrl_lane.sv]
// One resource class: totals, peak and capacity checks for that class.
module rrl_lane #(
  parameter int QTY_BITS = rrl_pkg::DEF_QTY_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cap_we,
  input  logic [rrl_pkg::FIELD_BITS-1:0] cap_wdata,
  input  logic [QTY_BITS-1:0] req_amt,
  input  logic [QTY_BITS-1:0] slot_amt,
  input  logic do_reserve,
  input  logic do_sub_res,
  input  logic do_sub_used,
  input  logic do_add_used,
  output rrl_pkg::lane_flags_t flags,
  output logic [QTY_BITS-1:0] res_o,
  output logic [QTY_BITS-1:0] used_o,
  output logic [QTY_BITS-1:0] peak_o
);
  import rrl_pkg::*;
  logic [QTY_BITS-1:0] cap_r, res_r, used_r, peak_r;
  logic [QTY_BITS-1:0] res_nxt, used_nxt, peak_nxt, sum, head;

  always_comb begin
    head = cap_r - res_r;
    flags.nonzero = (req_amt != '0);
    flags.fits = (res_r <= cap_r) && (used_r <= head) && (req_amt <= head - used_r);
    flags.res_holds = (slot_amt <= res_r);
    flags.used_holds = (slot_amt <= used_r);
    res_nxt = res_r;
    used_nxt = used_r;
    peak_nxt = peak_r;
    if (do_reserve) begin
      res_nxt = res_r + req_amt;
      sum = res_nxt + used_r;
      if (sum > peak_r) peak_nxt = sum;
    end else begin
      sum = '0;
    end
    if (do_sub_res) res_nxt = res_r - slot_amt;
    if (do_sub_used) used_nxt = used_r - slot_amt;
    if (do_add_used) used_nxt = used_r + slot_amt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
      res_r <= '0;
      used_r <= '0;
      peak_r <= '0;
    end else begin
      if (cap_we) cap_r <= QTY_BITS'(cap_wdata);
      res_r <= res_nxt;
      used_r <= used_nxt;
      peak_r <= peak_nxt;
    end
  end

  assign res_o = res_r;
  assign used_o = used_r;
  assign peak_o = peak_r;
endmodule

[sv/rrl_slots.sv]
// Slot table: valid and committed bits, lowest free slot and the amount memory.
module rrl_slots #(
  parameter int NUM_CLASSES = rrl_pkg::DEF_NUM_CLASSES,
  parameter int SLOT_COUNT = rrl_pkg::DEF_SLOT_COUNT,
  parameter int QTY_BITS = rrl_pkg::DEF_QTY_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [rrl_pkg::SLOT_BITS-1:0] rd_slot,
  output logic [NUM_CLASSES-1:0][QTY_BITS-1:0] rd_amt,
  input  logic alloc,
  input  logic [NUM_CLASSES-1:0][QTY_BITS-1:0] alloc_amt,
  input  logic commit,
  input  logic free,
  input  logic [rrl_pkg::SLOT_BITS-1:0] upd_slot,
  output logic slot_ok,
  output logic slot_comm,
  output logic have_free,
  output logic [$clog2(SLOT_COUNT+1)-1:0] free_idx
);
  import rrl_pkg::*;
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW = $clog2(SLOT_COUNT+1);
  logic [SLOT_COUNT-1:0] valid_r, comm_r;
  logic [NUM_CLASSES*QTY_BITS-1:0] mem [SLOT_COUNT];
  logic [NUM_CLASSES*QTY_BITS-1:0] rd_r;
  logic in_range;
  logic [IW-1:0] rd_idx, upd_idx;

  always_comb begin
    in_range = (32'(rd_slot) < SLOT_COUNT);
    rd_idx = IW'(rd_slot);
    upd_idx = IW'(upd_slot);
    slot_ok = in_range && valid_r[rd_idx];
    slot_comm = comm_r[rd_idx];
    have_free = 1'b0;
    free_idx = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        have_free = 1'b1;
        free_idx = FW'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_idx];
    if (alloc) mem[IW'(free_idx)] <= alloc_amt;
  end

  assign rd_amt = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      comm_r <= '0;
    end else if (alloc) begin
      valid_r[IW'(free_idx)] <= 1'b1;
      comm_r[IW'(free_idx)] <= 1'b0;
    end else if (commit) begin
      comm_r[upd_idx] <= 1'b1;
    end else if (free) begin
      valid_r[upd_idx] <= 1'b0;
      comm_r[upd_idx] <= 1'b0;
    end
  end
endmodule

[tb/rrl_tb_ledger_pkg.sv]
// Scoreboard class that predicts and checks the ledger's responses.
package rrl_tb_ledger_pkg;
  import rrl_pkg::*;

  class ledger_scoreboard;
    logic [47:0] cap[8];
    logic [47:0] res_tot[8];
    logic [47:0] used_tot[8];
    logic [47:0] peak_tot[8];
    bit slot_busy[16];
    bit slot_done[16];
    logic [47:0] slot_amt[16][8];
    rsp_t pending[$];
    int mismatches;
    int responses;

    function new();
      for (int c = 0; c < 8; c++) begin
        cap[c] = '0;
        res_tot[c] = '0;
        used_tot[c] = '0;
        peak_tot[c] = '0;
      end
      for (int s = 0; s < 16; s++) begin
        slot_busy[s] = 0;
        slot_done[s] = 0;
      end
      mismatches = 0;
      responses = 0;
    endfunction

    function void set_capacity(int idx, logic [47:0] val);
      cap[idx] = val;
    endfunction

    function bit covers(logic [47:0] acct[8], logic [47:0] amt[8]);
      for (int c = 0; c < 8; c++)
        if (amt[c] > acct[c]) return 0;
      return 1;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      logic [47:0] a[8];
      logic [47:0] sum;
      bit any;
      bit fit;
      int fs;
      int s;
      s = r.slot;
      e = '0;
      e.status = ST_STATE;
      e.granted_slot = r.slot;
      for (int c = 0; c < 8; c++) a[c] = r.amount[c];
      case (r.command)
        CMD_RESERVE: begin
          any = 0;
          fit = 1;
          for (int c = 0; c < 8; c++) begin
            if (a[c] != 0) any = 1;
            if (res_tot[c] > cap[c]) fit = 0;
            else if (used_tot[c] > cap[c] - res_tot[c]) fit = 0;
            else if (a[c] > cap[c] - res_tot[c] - used_tot[c]) fit = 0;
          end
          fs = -1;
          for (int i = 15; i >= 0; i--) if (!slot_busy[i]) fs = i;
          if (!any) e.status = ST_EMPTY;
          else if (!fit) e.status = ST_EXHAUSTED;
          else if (fs < 0) e.status = ST_NO_SLOT;
          else begin
            slot_busy[fs] = 1;
            slot_done[fs] = 0;
            for (int c = 0; c < 8; c++) begin
              slot_amt[fs][c] = a[c];
              res_tot[c] = res_tot[c] + a[c];
              sum = res_tot[c] + used_tot[c];
              if (sum > peak_tot[c]) peak_tot[c] = sum;
            end
            e.granted_slot = 4'(fs);
            e.status = ST_OK;
          end
        end
        CMD_COMMIT, CMD_ROLLBACK: begin
          if (slot_busy[s] && !slot_done[s]) begin
            if (!covers(res_tot, slot_amt[s])) e.status = ST_UNDERFLOW;
            else begin
              for (int c = 0; c < 8; c++) res_tot[c] = res_tot[c] - slot_amt[s][c];
              if (r.command == CMD_COMMIT) begin
                for (int c = 0; c < 8; c++) used_tot[c] = used_tot[c] + slot_amt[s][c];
                slot_done[s] = 1;
              end else begin
                slot_busy[s] = 0;
              end
              e.status = ST_OK;
            end
          end
        end
        CMD_RELEASE: begin
          if (slot_busy[s]) begin
            if (slot_done[s]) begin
              if (covers(used_tot, slot_amt[s])) begin
                for (int c = 0; c < 8; c++) used_tot[c] = used_tot[c] - slot_amt[s][c];
                e.status = ST_OK;
              end else e.status = ST_UNDERFLOW;
            end else begin
              if (covers(res_tot, slot_amt[s])) begin
                for (int c = 0; c < 8; c++) res_tot[c] = res_tot[c] - slot_amt[s][c];
                e.status = ST_OK;
              end else e.status = ST_UNDERFLOW;
            end
            slot_busy[s] = 0;
            slot_done[s] = 0;
          end
        end
        CMD_SNAPSHOT: begin
          e.reserved_level = res_tot[r.class_select];
          e.used_level = used_tot[r.class_select];
          e.peak_level = peak_tot[r.class_select];
          e.status = ST_OK;
        end
        default: ;
      endcase
      pending = {pending, e};
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      responses++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on response %0d: expected %p, got %p", responses, e, got);
      end
    endfunction
  endclass
endpackage

[tb/resource_reservation_ledger_top_tb.sv]
// Top-level testbench of the resource reservation ledger with directed and random requests.
module resource_reservation_ledger_top_tb;
  import rrl_pkg::*;
  import rrl_tb_ledger_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  logic clk = 0;
  logic rst_n = 0;
  bit quiet_mode = 0;
  bit done = 0;
  int idle_cycles = 0;
  ledger_scoreboard ledger;

  rrl_req_if req_ch();
  rrl_rsp_if rsp_ch();
  rrl_cfg_if cfg_ch();

  resource_reservation_ledger_top u_top (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_rsp(rsp_ch.source),
    .cfg_wr(cfg_ch.sink)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    ledger = new();
  end

  // Sampling at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) ledger.check_response(rsp_ch.data);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || done)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** resource_reservation_ledger_top: FAILED **");
      $finish;
    end
  end

  // Receiver stalls in bursts.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        rsp_ch.ready <= 0;
        repeat (n) @(negedge clk);
      end
      rsp_ch.ready <= 1;
    end
  end

  task automatic write_capacity(input int idx, input logic [47:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx[2:0];
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    ledger.set_capacity(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  task automatic send_request(input req_t r);
    int n;
    @(negedge clk);
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      req_ch.valid <= 0;
      repeat (n) @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ledger.note_request(r);
    @(negedge clk);
    req_ch.valid <= 0;
  endtask

  task automatic drain;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_t make_request(input logic [2:0] cmd, input logic [3:0] slot,
                                        input logic [2:0] sel, input logic [47:0] a);
    req_t r;
    r.command = cmd;
    r.slot = slot;
    r.class_select = sel;
    for (int c = 0; c < 8; c++) r.amount[c] = a;
    return r;
  endfunction

  function automatic logic [47:0] rand48(input int mode);
    logic [47:0] v;
    case (mode)
      0: v = 48'($urandom_range(0, 20));
      1: v = 48'({$urandom(), $urandom()});
      2: v = '0;
      default: v = 48'($urandom_range(0, 3000));
    endcase
    return v;
  endfunction

  function automatic req_t random_request(input bit wild);
    req_t r;
    int m;
    r.slot = 4'($urandom_range(0, 15));
    r.class_select = 3'($urandom_range(0, 7));
    m = $urandom_range(0, 99);
    if (m < 40) r.command = CMD_RESERVE;
    else if (m < 55) r.command = CMD_COMMIT;
    else if (m < 65) r.command = CMD_ROLLBACK;
    else if (m < 82) r.command = CMD_RELEASE;
    else if (m < 96) r.command = CMD_SNAPSHOT;
    else r.command = 3'($urandom_range(5, 7));
    for (int c = 0; c < 8; c++)
      r.amount[c] = rand48(wild ? $urandom_range(0, 3) : ($urandom_range(0, 5) == 0 ? 2 : 3));
    return r;
  endfunction

  initial begin
    req_t r;
    int k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed part with zero capacity first.
    send_request(make_request(CMD_RESERVE, 4'd0, 3'd0, '0));
    send_request(make_request(CMD_RESERVE, 4'd0, 3'd0, 48'd1));
    send_request(make_request(CMD_SNAPSHOT, 4'd0, 3'd7, '0));
    drain();
    for (int c = 0; c < 8; c++) write_capacity(c, MAX48);
    send_request(make_request(CMD_RESERVE, 4'd15, 3'd0, MAX48));
    send_request(make_request(CMD_SNAPSHOT, 4'd0, 3'd3, '0));
    send_request(make_request(CMD_RESERVE, 4'd0, 3'd0, 48'd1));
    send_request(make_request(CMD_COMMIT, 4'd0, 3'd0, '0));
    send_request(make_request(CMD_COMMIT, 4'd0, 3'd0, '0));
    send_request(make_request(CMD_ROLLBACK, 4'd0, 3'd0, '0));
    send_request(make_request(CMD_SNAPSHOT, 4'd0, 3'd0, '0));
    send_request(make_request(CMD_RELEASE, 4'd0, 3'd0, '0));
    send_request(make_request(CMD_RELEASE, 4'd0, 3'd0, '0));
    send_request(make_request(CMD_COMMIT, 4'd15, 3'd0, '0));
    for (int i = 0; i < 16; i++) send_request(make_request(CMD_RESERVE, 4'd0, 3'd0, 48'd1));
    send_request(make_request(CMD_RESERVE, 4'd0, 3'd0, 48'd1));
    send_request(make_request(3'd7, 4'd5, 3'd5, MAX48));
    send_request(make_request(CMD_ROLLBACK, 4'd3, 3'd0, '0));
    send_request(make_request(CMD_SNAPSHOT, 4'd0, 3'd1, '0));
    for (int i = 0; i < 16; i++) send_request(make_request(CMD_RELEASE, i[3:0], 3'd0, '0));
    drain();

    // Random phases over several capacity settings.
    for (int phase = 0; phase < 6; phase++) begin
      for (int c = 0; c < 8; c++) begin
        case (phase)
          0: write_capacity(c, 48'($urandom_range(0, 40)));
          1: write_capacity(c, MAX48);
          2: write_capacity(c, 48'($urandom_range(1000, 8000)));
          3: write_capacity(c, 48'({$urandom(), $urandom()}));
          4: write_capacity(c, (c % 2) ? MAX48 : 48'($urandom_range(0, 5000)));
          default: write_capacity(c, 48'($urandom_range(2000, 20000)));
        endcase
      end
      if (phase == 5) quiet_mode = 1;
      for (k = 0; k < 150; k++) begin
        r = random_request(phase == 1 || phase == 3);
        send_request(r);
      end
      drain();
    end

    done = 1;
    if (ledger.mismatches == 0 && ledger.pending.size() == 0)
      $display("** resource_reservation_ledger_top: PASSED **");
    else
      $display("** resource_reservation_ledger_top: FAILED **");
    $finish;
  end
endmodule
